// ----- rtl/tkd_pkg.sv -----
// shared types and constants for the terminal key decoder
package tkd_pkg;

  localparam int KEY_W  = 9;
  localparam int BYTE_W = 8;
  localparam int SIZE_W = 10;
  localparam int CFG_ADDR_W = 1;

  typedef logic [KEY_W-1:0]      key_code_t;
  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  // decoded key request from the parser to the cursor side
  typedef struct packed {
    logic      valid;
    key_code_t code;
  } key_req_t;

  // extended key codes
  localparam key_code_t KEY_ESC   = 9'h01b;
  localparam key_code_t KEY_QUIT  = 9'h011;
  localparam key_code_t KEY_LEFT  = 9'd256;
  localparam key_code_t KEY_RIGHT = 9'd257;
  localparam key_code_t KEY_UP    = 9'd258;
  localparam key_code_t KEY_DOWN  = 9'd259;
  localparam key_code_t KEY_DEL   = 9'd260;
  localparam key_code_t KEY_HOME  = 9'd261;
  localparam key_code_t KEY_END   = 9'd262;
  localparam key_code_t KEY_PGUP  = 9'd263;
  localparam key_code_t KEY_PGDN  = 9'd264;

  // configuration register indexes
  localparam cfg_addr_t CFG_SCREEN_ROWS = 1'b0;
  localparam cfg_addr_t CFG_SCREEN_COLS = 1'b1;

  localparam size_t ROWS_RESET = 10'd24;
  localparam size_t COLS_RESET = 10'd80;

endpackage

// ----- rtl/terminal_key_decoder_cursor.sv -----
// top level: vt100 key decoder driving a clamped text cursor
//
// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  tdata: byte[7:0]; tuser: kind[0]
// out_      out  out_tvalid/out_tready tdata: code[8:0] col[18:9] row[28:19]; tuser: valid, quit
// cfg_      in   cfg_we               cfg_addr: register index, cfg_wdata: value
//
// one request per cycle in and out while in_tready and out_tready are high
// a completed key goes from the parser through the two-entry queue to the output register
// in_tready drops only when the key queue is full under output backpressure
// synchronous active-low reset; screen size resets to 24 rows by 80 columns
module terminal_key_decoder_cursor #(
  parameter int COORD_WIDTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte[7:0]
  input  logic [0:0]  in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // key_code[8:0], cursor_col[18:9], cursor_row[28:19], zero
  output logic [1:0]  out_tuser,  // key_valid[0], quit[1]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata
);

  logic               accept;
  logic               q_full, q_avail, q_pop;
  tkd_pkg::key_req_t  req;
  tkd_pkg::key_code_t q_head;
  tkd_pkg::key_code_t out_key;
  tkd_pkg::size_t     out_col, out_row;
  logic               out_quit;

  assign in_tready = ~q_full;
  assign accept    = in_tvalid & in_tready;

  tkd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .timeout (in_tuser[0]),
    .rx_byte (in_tdata),
    .req     (req)
  );

  tkd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_avail),
    .head      (q_head)
  );

  tkd_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .key_avail (q_avail),
    .key_in    (q_head),
    .key_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_key   (out_key),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_quit  (out_quit)
  );

  assign out_tdata = {3'b000, out_row, out_col, out_key};
  assign out_tuser = {out_quit, 1'b1};

endmodule

// ----- rtl/tkd_front.sv -----
// escape sequence parser: classifies input bytes into key requests
module tkd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             timeout,
  input  tkd_pkg::byte_t   rx_byte,
  output tkd_pkg::key_req_t req
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_CSI,
    PH_SS3,
    PH_OTHER,
    PH_DIGIT
  } phase_t;

  localparam tkd_pkg::byte_t CH_ESC   = 8'h1b;
  localparam tkd_pkg::byte_t CH_LBRK  = 8'h5b;
  localparam tkd_pkg::byte_t CH_SS3   = 8'h4f;
  localparam tkd_pkg::byte_t CH_TILDE = 8'h7e;
  localparam tkd_pkg::byte_t CH_ZERO  = 8'h30;
  localparam tkd_pkg::byte_t CH_NINE  = 8'h39;
  localparam tkd_pkg::byte_t CH_A     = 8'h41;
  localparam tkd_pkg::byte_t CH_B     = 8'h42;
  localparam tkd_pkg::byte_t CH_C     = 8'h43;
  localparam tkd_pkg::byte_t CH_D     = 8'h44;
  localparam tkd_pkg::byte_t CH_F     = 8'h46;
  localparam tkd_pkg::byte_t CH_H     = 8'h48;
  localparam tkd_pkg::byte_t CH_1     = 8'h31;
  localparam tkd_pkg::byte_t CH_3     = 8'h33;
  localparam tkd_pkg::byte_t CH_4     = 8'h34;
  localparam tkd_pkg::byte_t CH_5     = 8'h35;
  localparam tkd_pkg::byte_t CH_6     = 8'h36;
  localparam tkd_pkg::byte_t CH_7     = 8'h37;
  localparam tkd_pkg::byte_t CH_8     = 8'h38;

  function automatic tkd_pkg::key_code_t digit_key(input tkd_pkg::byte_t d);
    tkd_pkg::key_code_t k;
    unique case (d)
      CH_1, CH_7: k = tkd_pkg::KEY_HOME;
      CH_3:       k = tkd_pkg::KEY_DEL;
      CH_4, CH_8: k = tkd_pkg::KEY_END;
      CH_5:       k = tkd_pkg::KEY_PGUP;
      CH_6:       k = tkd_pkg::KEY_PGDN;
      default:    k = tkd_pkg::KEY_ESC;
    endcase
    return k;
  endfunction

  phase_t         phase_r, phase_nxt;
  tkd_pkg::byte_t digit_r, digit_nxt;
  logic               done;
  tkd_pkg::key_code_t key;

  always_comb begin
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    done      = 1'b0;
    key       = '0;
    if (timeout) begin
      if (phase_r != PH_IDLE) begin
        done = 1'b1;
        key  = tkd_pkg::KEY_ESC;
      end
      phase_nxt = PH_IDLE;
    end else begin
      unique case (phase_r)
        PH_ESC: begin
          if (rx_byte == CH_LBRK) phase_nxt = PH_CSI;
          else if (rx_byte == CH_SS3) phase_nxt = PH_SS3;
          else phase_nxt = PH_OTHER;
        end
        PH_CSI: begin
          phase_nxt = PH_IDLE;
          if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
            digit_nxt = rx_byte;
            phase_nxt = PH_DIGIT;
          end else begin
            done = 1'b1;
            unique case (rx_byte)
              CH_A:    key = tkd_pkg::KEY_UP;
              CH_B:    key = tkd_pkg::KEY_DOWN;
              CH_C:    key = tkd_pkg::KEY_RIGHT;
              CH_D:    key = tkd_pkg::KEY_LEFT;
              CH_H:    key = tkd_pkg::KEY_HOME;
              CH_F:    key = tkd_pkg::KEY_END;
              default: key = tkd_pkg::KEY_ESC;
            endcase
          end
        end
        PH_SS3: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          if (rx_byte == CH_H) key = tkd_pkg::KEY_HOME;
          else if (rx_byte == CH_F) key = tkd_pkg::KEY_END;
          else key = tkd_pkg::KEY_ESC;
        end
        PH_OTHER: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          key       = tkd_pkg::KEY_ESC;
        end
        PH_DIGIT: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          key       = (rx_byte == CH_TILDE) ? digit_key(digit_r) : tkd_pkg::KEY_ESC;
        end
        default: begin
          if (rx_byte == CH_ESC) begin
            phase_nxt = PH_ESC;
          end else begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
            key       = {1'b0, rx_byte};
          end
        end
      endcase
    end
  end

  assign req.valid = accept & done;
  assign req.code  = key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      digit_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

// ----- rtl/tkd_fifo.sv -----
// two-entry key queue between parser and cursor logic
module tkd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tkd_pkg::key_req_t     push,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output tkd_pkg::key_code_t    head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  tkd_pkg::key_code_t      mem_r [DEPTH];
  logic [PTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]          count_r;
  logic                    do_pop;

  assign full      = (count_r == (PTR_W+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop & not_empty;

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push.valid && !do_pop) count_r <= count_r + 1'b1;
      else if (!push.valid && do_pop) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- rtl/tkd_back.sv -----
// cursor update, screen size registers and output register
module tkd_back #(
  parameter int COORD_WIDTH = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  tkd_pkg::cfg_addr_t  cfg_addr,
  input  tkd_pkg::size_t      cfg_wdata,
  input  logic                key_avail,
  input  tkd_pkg::key_code_t  key_in,
  output logic                key_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tkd_pkg::key_code_t  out_key,
  output tkd_pkg::size_t      out_col,
  output tkd_pkg::size_t      out_row,
  output logic                out_quit
);

  localparam int SW = (COORD_WIDTH > tkd_pkg::SIZE_W) ? COORD_WIDTH + 1 : tkd_pkg::SIZE_W + 1;
  localparam logic [SW-1:0] CMAX = {{(SW-COORD_WIDTH){1'b0}}, {COORD_WIDTH{1'b1}}};

  tkd_pkg::size_t           rows_r, cols_r;
  logic [COORD_WIDTH-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic                     out_valid_r;
  tkd_pkg::key_code_t       out_key_r;
  tkd_pkg::size_t           out_col_r, out_row_r;
  logic                     out_quit_r;
  logic [SW-1:0]            col_ext, row_ext, cols_ext, rows_ext;
  logic [SW-1:0]            col_last, row_last;
  logic [SW-1:0]            col_nxt_ext, row_nxt_ext;

  function automatic logic [SW-1:0] last_index(input tkd_pkg::size_t size);
    logic [SW-1:0] v;
    v = (size == '0) ? '0 : SW'(size - 1'b1);
    return (v > CMAX) ? CMAX : v;
  endfunction

  assign key_pop  = key_avail & (~out_valid_r | out_ready);
  assign col_ext  = SW'(col_r);
  assign row_ext  = SW'(row_r);
  assign cols_ext = SW'(cols_r);
  assign rows_ext = SW'(rows_r);
  assign col_last = last_index(cols_r);
  assign row_last = last_index(rows_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    unique case (key_in)
      tkd_pkg::KEY_LEFT:  if (col_r != '0) col_nxt = col_r - 1'b1;
      tkd_pkg::KEY_RIGHT: if (col_ext + 1'b1 < cols_ext && col_ext < CMAX) col_nxt = col_r + 1'b1;
      tkd_pkg::KEY_UP:    if (row_r != '0) row_nxt = row_r - 1'b1;
      tkd_pkg::KEY_DOWN:  if (row_ext + 1'b1 < rows_ext && row_ext < CMAX) row_nxt = row_r + 1'b1;
      tkd_pkg::KEY_HOME:  col_nxt = '0;
      tkd_pkg::KEY_END:   col_nxt = col_last[COORD_WIDTH-1:0];
      tkd_pkg::KEY_PGUP:  row_nxt = '0;
      tkd_pkg::KEY_PGDN:  row_nxt = row_last[COORD_WIDTH-1:0];
      default: ;
    endcase
  end

  assign col_nxt_ext = SW'(col_nxt);
  assign row_nxt_ext = SW'(row_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= tkd_pkg::ROWS_RESET;
      cols_r      <= tkd_pkg::COLS_RESET;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == tkd_pkg::CFG_SCREEN_ROWS) rows_r <= cfg_wdata;
      if (cfg_we && cfg_addr == tkd_pkg::CFG_SCREEN_COLS) cols_r <= cfg_wdata;
      if (key_pop) begin
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_pop) begin
      out_key_r  <= key_in;
      out_col_r  <= col_nxt_ext[tkd_pkg::SIZE_W-1:0];
      out_row_r  <= row_nxt_ext[tkd_pkg::SIZE_W-1:0];
      out_quit_r <= (key_in == tkd_pkg::KEY_QUIT);
    end
  end

  assign out_valid = out_valid_r;
  assign out_key   = out_key_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;
  assign out_quit  = out_quit_r;

endmodule

// ----- rtl/tkd_checker.sv -----
// port-level checks for the terminal key decoder, bound to the top level
module tkd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // quit flag matches ctrl-q key
  a_quit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1] == (out_tdata[8:0] == tkd_pkg::KEY_QUIT) && out_tuser[0])
    else $error("quit flag does not match key");

  // key code within the defined set
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:0] <= tkd_pkg::KEY_PGDN)
    else $error("key code out of range");

  // input stalls only while a result waits, and an offered request is fully defined
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_tready |-> out_tvalid) and (in_tvalid |-> !$isunknown({in_tuser, in_tdata})))
    else $error("input stalled with no waiting result or undefined request");

endmodule

bind terminal_key_decoder_cursor tkd_checker u_tkd_checker (.*);
